// File: rtl/dmcu_pkg.sv
// Shared types, codes and defaults for the dispersive-medium cell update block.
package dmcu_pkg;

  // Fixed widths of the beat fields and the coefficient registers
  localparam int FIELD_W = 32;
  localparam int COEF_W = 32;
  localparam int REG_IDX_W = 3;

  // Defaults for the top-level parameters
  localparam int DATA_WIDTH_DEF = 32;
  localparam int COEF_FRAC_BITS_DEF = 24;

  // Register indexes of the configuration port
  typedef enum logic [REG_IDX_W-1:0] {
    REG_MEDIUM_KIND = 3'd0,
    REG_COEF_CA = 3'd1,
    REG_COEF_CB = 3'd2,
    REG_COEF_CC = 3'd3,
    REG_COEF_ALPHA = 3'd4,
    REG_COEF_XI = 3'd5,
    REG_COEF_DRIVE = 3'd6,
    REG_COEF_HALF_DL = 3'd7
  } reg_idx_t;

  // Medium update rules; the unused code behaves as Debye
  typedef enum logic [1:0] {
    MEDIUM_LORENTZ = 2'd0,
    MEDIUM_DRUDE = 2'd1,
    MEDIUM_DEBYE = 2'd2
  } medium_kind_t;

  // One cell beat on the input side
  typedef struct packed {
    logic signed [FIELD_W-1:0] e_now;
    logic signed [FIELD_W-1:0] e_prev;
    logic signed [FIELD_W-1:0] j_now;
    logic signed [FIELD_W-1:0] j_prev;
    logic signed [FIELD_W-1:0] h_first_here;
    logic signed [FIELD_W-1:0] h_first_back;
    logic signed [FIELD_W-1:0] h_second_here;
    logic signed [FIELD_W-1:0] h_second_back;
  } cell_beat_t;

  // One update beat on the output side
  typedef struct packed {
    logic signed [FIELD_W-1:0] e_new;
    logic signed [FIELD_W-1:0] j_new;
    logic signed [FIELD_W-1:0] e_prev_out;
    logic signed [FIELD_W-1:0] j_prev_out;
  } upd_beat_t;

  // Load enables of the two register stages of a multiply unit
  typedef struct packed {
    logic mul;
    logic rnd;
  } dmcu_en_t;

endpackage

// File: rtl/dmcu_mul_rnd.sv
// Two-stage coefficient multiply with round-half-away and saturation.
module dmcu_mul_rnd #(
  parameter int DATA_WIDTH = dmcu_pkg::DATA_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = dmcu_pkg::COEF_FRAC_BITS_DEF,
  parameter int IW = 32,
  parameter int CW = 33
) (
  input  logic                 clk,
  input  dmcu_pkg::dmcu_en_t   en,
  input  logic signed [CW-1:0] coef,
  input  logic signed [IW-1:0] x,
  output logic signed [IW-1:0] res
);
  import dmcu_pkg::*;

  localparam int PW = CW + IW;
  localparam logic [PW:0] BIAS =
    {{(PW + 1 - COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS - 1){1'b0}}};
  localparam logic [PW:0] LIM = {{(PW - DATA_WIDTH + 2){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [IW-1:0] SAT_HI =
    {{(IW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [IW-1:0] SAT_LO = ~SAT_HI;

  logic signed [PW-1:0] prod;
  logic [PW-1:0] mag;
  logic [PW:0] rsum;
  logic [PW:0] rshift;
  logic signed [IW-1:0] res_next;

  // Stage one: full-width signed product
  always_ff @(posedge clk) begin
    if (en.mul) begin
      prod <= coef * x;
    end
  end

  // Round the magnitude, then saturate and restore the sign
  always_comb begin
    mag = prod[PW-1] ? PW'(~prod + 1'b1) : prod;
    rsum = {1'b0, mag} + BIAS;
    rshift = rsum >> COEF_FRAC_BITS;
    if (rshift > LIM) begin
      res_next = prod[PW-1] ? SAT_LO : SAT_HI;
    end else if (prod[PW-1]) begin
      res_next = IW'(~rshift + 1'b1);
    end else begin
      res_next = rshift[IW-1:0];
    end
  end

  // Stage two: rounded result
  always_ff @(posedge clk) begin
    if (en.rnd) begin
      res <= res_next;
    end
  end

endmodule

// File: rtl/dispersive_medium_cell_update.sv
// Top level of the dispersive-medium cell update pipeline.
//
// Each cell beat yields one update beat at the output, passing through thirteen
// register stages (the last one being the output register), and a new cell beat
// can be taken in every cycle unless the input is stalled, so the sustained
// rate is one cell per clock. The depth is set by the dependent chain current
// sum, field update, current update: four multiply-and-round units one after
// another (one plus alpha times current, half cell size, curl weight, drive;
// each a product stage and a rounding stage) with saturating add stages between
// them. Every stage holds its own valid bit; a stage takes new data whenever it
// is empty or its successor moves, so bubbles close up and the input keeps
// flowing into empty stages while a finished update waits at the output. The
// input is stalled only when all thirteen stages are full and the output beat
// is blocked. Configuration must be written by the user only while the
// pipeline is empty; the block does not enforce it. A write takes effect for
// the cell beat taken at the next edge. There is no clearing pass after reset.
module dispersive_medium_cell_update #(
  parameter int DATA_WIDTH = dmcu_pkg::DATA_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = dmcu_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cell_valid,
  output logic                               cell_stall,
  input  dmcu_pkg::cell_beat_t               cell_beat,
  output logic                               upd_valid,
  input  logic                               upd_stall,
  output dmcu_pkg::upd_beat_t                upd,
  input  logic                               cfg_we,
  input  logic [dmcu_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [dmcu_pkg::COEF_W-1:0]        cfg_data
);
  import dmcu_pkg::*;

  localparam int IW = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;
  localparam int CW = COEF_W + 1;
  localparam int NS = 13;
  localparam logic signed [IW:0] SAT_HI =
    {{(IW - DATA_WIDTH + 2){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [IW:0] SAT_LO = ~SAT_HI;
  localparam logic signed [CW-1:0] COEF_ONE = CW'(64'd1 << COEF_FRAC_BITS);

  // Clamp a grown sum to the signed data range
  function automatic logic signed [IW-1:0] sat_sum(input logic signed [IW:0] v);
    logic signed [IW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[IW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[IW-1:0];
    end else begin
      r = v[IW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [IW-1:0] add_sat(input logic signed [IW-1:0] a,
                                                   input logic signed [IW-1:0] b);
    return sat_sum((IW + 1)'(a) + (IW + 1)'(b));
  endfunction

  function automatic logic signed [IW-1:0] sub_sat(input logic signed [IW-1:0] a,
                                                   input logic signed [IW-1:0] b);
    return sat_sum((IW + 1)'(a) - (IW + 1)'(b));
  endfunction

  // Configuration registers
  logic [1:0] medium_kind;
  logic signed [COEF_W-1:0] coef_ca;
  logic signed [COEF_W-1:0] coef_cb;
  logic signed [COEF_W-1:0] coef_cc;
  logic signed [COEF_W-1:0] coef_alpha;
  logic signed [COEF_W-1:0] coef_xi;
  logic signed [COEF_W-1:0] coef_drive;
  logic signed [COEF_W-1:0] coef_half_dl;
  logic signed [CW-1:0] alpha_one;

  // Pipeline control
  logic [NS:1] vld;
  logic [NS+1:1] ready;

  // Carried operands and stage results
  logic signed [FIELD_W-1:0] e_now_p [1:NS-1];
  logic signed [FIELD_W-1:0] j_now_p [1:NS-1];
  logic signed [IW-1:0] e_prev_p [1:9];
  logic signed [IW-1:0] d2_1;
  logic signed [IW-1:0] d1_1;
  logic signed [IW-1:0] curl_p [2:5];
  logic signed [IW-1:0] jpart_p [3:NS-1];
  logic signed [IW-1:0] epart_p [3:8];
  logic signed [IW-1:0] inner_3;
  logic signed [IW-1:0] drv_6;
  logic signed [IW-1:0] enew_p [9:NS-1];
  logic signed [IW-1:0] diff_10;

  // Multiply unit outputs
  logic signed [IW-1:0] r_xi;
  logic signed [IW-1:0] r_a1;
  logic signed [IW-1:0] r_a;
  logic signed [IW-1:0] r_ca;
  logic signed [IW-1:0] r_cb;
  logic signed [IW-1:0] r_jsum;
  logic signed [IW-1:0] r_cc;
  logic signed [IW-1:0] r_drive;

  // Stage logic
  logic signed [IW-1:0] e_now_x;
  logic signed [IW-1:0] e_prev_x;
  logic signed [IW-1:0] j_now_x;
  logic signed [IW-1:0] j_prev_x;
  logic signed [IW-1:0] xterm;
  logic signed [IW-1:0] cb_term;
  logic signed [IW-1:0] diff_next;
  logic signed [IW-1:0] jnew_next;
  logic lorentz;
  logic drude;

  // Write configuration registers; one plus alpha is formed with alpha
  always_ff @(posedge clk) begin
    if (rst) begin
      medium_kind <= '0;
      coef_ca <= '0;
      coef_cb <= '0;
      coef_cc <= '0;
      coef_alpha <= '0;
      coef_xi <= '0;
      coef_drive <= '0;
      coef_half_dl <= '0;
      alpha_one <= COEF_ONE;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MEDIUM_KIND: medium_kind <= cfg_data[1:0];
        REG_COEF_CA: coef_ca <= cfg_data;
        REG_COEF_CB: coef_cb <= cfg_data;
        REG_COEF_CC: coef_cc <= cfg_data;
        REG_COEF_ALPHA: begin
          coef_alpha <= cfg_data;
          alpha_one <= CW'($signed(cfg_data)) + COEF_ONE;
        end
        REG_COEF_XI: coef_xi <= cfg_data;
        REG_COEF_DRIVE: coef_drive <= cfg_data;
        REG_COEF_HALF_DL: coef_half_dl <= cfg_data;
      endcase
    end
  end

  // Propagate ready back from the output register
  always_comb begin
    ready[NS+1] = !upd_stall;
    for (int k = NS; k >= 1; k--) begin
      ready[k] = !vld[k] || ready[k+1];
    end
  end

  assign cell_stall = !ready[1];
  assign upd_valid = vld[NS];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ready[1]) begin
        vld[1] <= cell_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (ready[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Decode the medium, widen the inputs and form the field difference and new current
  always_comb begin
    lorentz = (medium_kind == MEDIUM_LORENTZ);
    drude = (medium_kind == MEDIUM_DRUDE);
    e_now_x = IW'($signed(cell_beat.e_now));
    e_prev_x = IW'($signed(cell_beat.e_prev));
    j_now_x = IW'($signed(cell_beat.j_now));
    j_prev_x = IW'($signed(cell_beat.j_prev));
    xterm = lorentz ? r_xi : '0;
    cb_term = lorentz ? r_cb : '0;
    priority if (lorentz) begin
      diff_next = sub_sat(enew_p[9], e_prev_p[9]);
    end else if (drude) begin
      diff_next = add_sat(enew_p[9], IW'($signed(e_now_p[9])));
    end else begin
      diff_next = sub_sat(enew_p[9], IW'($signed(e_now_p[9])));
    end
    jnew_next = add_sat(jpart_p[NS-1], r_drive);
  end

  // Stage one: curl differences, carry the cell fields
  always_ff @(posedge clk) begin
    if (ready[1]) begin
      d2_1 <= sub_sat(IW'($signed(cell_beat.h_second_here)),
                      IW'($signed(cell_beat.h_second_back)));
      d1_1 <= sub_sat(IW'($signed(cell_beat.h_first_back)),
                      IW'($signed(cell_beat.h_first_here)));
      e_now_p[1] <= cell_beat.e_now;
      j_now_p[1] <= cell_beat.j_now;
      e_prev_p[1] <= e_prev_x;
    end
  end

  // Carry the cell fields down the pipeline
  always_ff @(posedge clk) begin
    for (int k = 2; k <= NS - 1; k++) begin
      if (ready[k]) begin
        e_now_p[k] <= e_now_p[k-1];
        j_now_p[k] <= j_now_p[k-1];
      end
    end
    for (int k = 2; k <= 9; k++) begin
      if (ready[k]) begin
        e_prev_p[k] <= e_prev_p[k-1];
      end
    end
  end

  // Stage two: curl; stage three: current sum parts and field part
  always_ff @(posedge clk) begin
    if (ready[2]) begin
      curl_p[2] <= add_sat(d2_1, d1_1);
    end
    if (ready[3]) begin
      curl_p[3] <= curl_p[2];
      inner_3 <= add_sat(r_a1, xterm);
      jpart_p[3] <= add_sat(r_a, xterm);
      epart_p[3] <= add_sat(r_ca, cb_term);
    end
    for (int k = 4; k <= 5; k++) begin
      if (ready[k]) begin
        curl_p[k] <= curl_p[k-1];
      end
    end
    for (int k = 4; k <= 8; k++) begin
      if (ready[k]) begin
        epart_p[k] <= epart_p[k-1];
      end
    end
    for (int k = 4; k <= NS - 1; k++) begin
      if (ready[k]) begin
        jpart_p[k] <= jpart_p[k-1];
      end
    end
  end

  // Stage six: drive term; nine: new field; ten: field difference or sum
  always_ff @(posedge clk) begin
    if (ready[6]) begin
      drv_6 <= sub_sat(curl_p[5], r_jsum);
    end
    if (ready[9]) begin
      enew_p[9] <= add_sat(epart_p[8], r_cc);
    end
    if (ready[10]) begin
      diff_10 <= diff_next;
    end
    for (int k = 10; k <= NS - 1; k++) begin
      if (ready[k]) begin
        enew_p[k] <= enew_p[k-1];
      end
    end
  end

  // Output register: new field, new current and the stored beat
  always_ff @(posedge clk) begin
    if (ready[NS]) begin
      upd.e_new <= enew_p[NS-1][FIELD_W-1:0];
      upd.j_new <= jnew_next[FIELD_W-1:0];
      upd.e_prev_out <= e_now_p[NS-1];
      upd.j_prev_out <= j_now_p[NS-1];
    end
  end

  // Products of stage one, rounded in stage two
  dmcu_mul_rnd #(
    .DATA_WIDTH(DATA_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS), .IW(IW), .CW(CW)
  ) u_mul_xi (
    .clk(clk), .en('{mul: ready[1], rnd: ready[2]}),
    .coef(CW'(coef_xi)), .x(j_prev_x), .res(r_xi)
  );

  dmcu_mul_rnd #(
    .DATA_WIDTH(DATA_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS), .IW(IW), .CW(CW)
  ) u_mul_a1 (
    .clk(clk), .en('{mul: ready[1], rnd: ready[2]}),
    .coef(alpha_one), .x(j_now_x), .res(r_a1)
  );

  dmcu_mul_rnd #(
    .DATA_WIDTH(DATA_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS), .IW(IW), .CW(CW)
  ) u_mul_a (
    .clk(clk), .en('{mul: ready[1], rnd: ready[2]}),
    .coef(CW'(coef_alpha)), .x(j_now_x), .res(r_a)
  );

  dmcu_mul_rnd #(
    .DATA_WIDTH(DATA_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS), .IW(IW), .CW(CW)
  ) u_mul_ca (
    .clk(clk), .en('{mul: ready[1], rnd: ready[2]}),
    .coef(CW'(coef_ca)), .x(e_now_x), .res(r_ca)
  );

  dmcu_mul_rnd #(
    .DATA_WIDTH(DATA_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS), .IW(IW), .CW(CW)
  ) u_mul_cb (
    .clk(clk), .en('{mul: ready[1], rnd: ready[2]}),
    .coef(CW'(coef_cb)), .x(e_prev_x), .res(r_cb)
  );

  // Scaled current sum in stages four and five
  dmcu_mul_rnd #(
    .DATA_WIDTH(DATA_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS), .IW(IW), .CW(CW)
  ) u_mul_hdl (
    .clk(clk), .en('{mul: ready[4], rnd: ready[5]}),
    .coef(CW'(coef_half_dl)), .x(inner_3), .res(r_jsum)
  );

  // Curl weight in stages seven and eight
  dmcu_mul_rnd #(
    .DATA_WIDTH(DATA_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS), .IW(IW), .CW(CW)
  ) u_mul_cc (
    .clk(clk), .en('{mul: ready[7], rnd: ready[8]}),
    .coef(CW'(coef_cc)), .x(drv_6), .res(r_cc)
  );

  // Current drive in stages eleven and twelve
  dmcu_mul_rnd #(
    .DATA_WIDTH(DATA_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS), .IW(IW), .CW(CW)
  ) u_mul_drive (
    .clk(clk), .en('{mul: ready[11], rnd: ready[12]}),
    .coef(CW'(coef_drive)), .x(diff_10), .res(r_drive)
  );

  // The input is held back only when the first stage is occupied
  a_stall_needs_first: assert property (@(posedge clk) disable iff (rst)
    cell_stall |-> vld[1])
    else $error("input stalled with an empty first stage");

  // The input is held back only while the output beat is blocked
  a_stall_from_output: assert property (@(posedge clk) disable iff (rst)
    cell_stall |-> (upd_valid && upd_stall))
    else $error("input stalled without a blocked output");

  // A delivered beat with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (upd_valid && !upd_stall && !vld[NS-1]) |=> !upd_valid)
    else $error("output beat repeated after delivery");

endmodule
